// ----- rtl/core/smlr_pkg.sv -----
// Shared constants and types for the substring match line reporter.
// Depends on nothing; every other file of the block uses it.
package smlr_pkg;

    // Field widths of the channels
    localparam int TEXT_W     = 8;
    localparam int LINE_W     = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_W      = 5;

    // Largest pattern the configuration registers can hold
    localparam int MAX_PATTERN_BYTES = 16;

    localparam logic [TEXT_W-1:0] NEWLINE_BYTE   = 8'h0A;
    localparam logic [LINE_W-1:0] LINE_MAX_VALUE = '1;

    // Queue depth between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2
    } t_cfg_reg;

endpackage

// ----- rtl/core/smlr_if.sv -----
// Valid/ready channel interfaces for text input, match output and configuration.
// Depends on smlr_pkg for the field widths.
interface smlr_text_if;
    logic                         valid;
    logic                         ready;
    logic [smlr_pkg::TEXT_W-1:0]  text_byte;
    logic                         starts_new_text;

    modport source (output valid, output text_byte, output starts_new_text, input ready);
    modport sink   (input valid, input text_byte, input starts_new_text, output ready);
endinterface

interface smlr_match_if;
    logic                         valid;
    logic                         ready;
    logic [smlr_pkg::LINE_W-1:0]  match_line;

    modport source (output valid, output match_line, input ready);
    modport sink   (input valid, input match_line, output ready);
endinterface

interface smlr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [smlr_pkg::CFG_IDX_W-1:0]   index;
    logic [smlr_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/smlr_front.sv -----
// Front: holds the pattern registers, accepts text bytes and classifies each
// byte into a pattern-position mask. Depends on smlr_pkg and smlr_if.
module smlr_front #(
    parameter int P_MAX_BYTES = smlr_pkg::MAX_PATTERN_BYTES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    smlr_cfg_if.sink               i_cfg,
    smlr_text_if.sink              i_text,
    input  logic                   i_queue_full,
    output logic                   o_push,
    output logic [2*P_MAX_BYTES+1:0] o_entry
);
    import smlr_pkg::*;

    typedef struct packed {
        logic                   fresh;
        logic                   newline;
        logic [P_MAX_BYTES-1:0] last;
        logic [P_MAX_BYTES-1:0] mask;
    } t_entry;

    logic [CFG_DATA_W-1:0]   r_pat_low;
    logic [CFG_DATA_W-1:0]   r_pat_high;
    logic [LEN_W-1:0]        r_pat_len;
    logic [2*CFG_DATA_W-1:0] w_pattern;
    logic [LEN_W-1:0]        w_len;
    t_entry                  w_entry;

    // Configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= LEN_W'(1);
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                CFG_PAT_LOW:  r_pat_low  <= i_cfg.data;
                CFG_PAT_HIGH: r_pat_high <= i_cfg.data;
                CFG_PAT_LEN:  r_pat_len  <= i_cfg.data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Clamp the length into 1..P_MAX_BYTES
    always_comb begin
        if (r_pat_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_pat_len > LEN_W'(P_MAX_BYTES)) begin
            w_len = LEN_W'(P_MAX_BYTES);
        end else begin
            w_len = r_pat_len;
        end
    end

    assign w_pattern = {r_pat_high, r_pat_low};

    // Compare the byte against every pattern position in use
    always_comb begin
        w_entry.fresh   = i_text.starts_new_text;
        w_entry.newline = (i_text.text_byte == NEWLINE_BYTE);
        for (int i = 0; i < P_MAX_BYTES; i++) begin
            w_entry.mask[i] = (w_pattern[8*i +: 8] == i_text.text_byte)
                              && (LEN_W'(i) < w_len);
            w_entry.last[i] = (w_len == LEN_W'(i + 1));
        end
    end

    assign i_text.ready = !i_queue_full;
    assign o_push       = i_text.valid && !i_queue_full;
    assign o_entry      = w_entry;

endmodule

// ----- rtl/core/smlr_queue.sv -----
// Short FIFO of classified bytes between the front and the back.
// Depends on smlr_pkg for the depth.
module smlr_queue #(
    parameter int P_WIDTH = 34
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [P_WIDTH-1:0] i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic [P_WIDTH-1:0] o_data,
    output logic               o_empty
);
    import smlr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [P_WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Advance the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/core/smlr_back.sv -----
// Back: runs the shift-and recurrence and the line count on queued entries
// and holds the match request in an output register. Depends on smlr_pkg, smlr_if.
module smlr_back #(
    parameter int P_MAX_BYTES = smlr_pkg::MAX_PATTERN_BYTES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  logic [2*P_MAX_BYTES+1:0] i_entry,
    output logic                     o_pop,
    smlr_match_if.source             o_match
);
    import smlr_pkg::*;

    typedef struct packed {
        logic                   fresh;
        logic                   newline;
        logic [P_MAX_BYTES-1:0] last;
        logic [P_MAX_BYTES-1:0] mask;
    } t_entry;

    t_entry                 w_entry;
    logic [P_MAX_BYTES-1:0] r_vec;
    logic [LINE_W-1:0]      r_line;
    logic [P_MAX_BYTES-1:0] w_base_vec;
    logic [LINE_W-1:0]      w_base_line;
    logic [P_MAX_BYTES-1:0] n_vec;
    logic [LINE_W-1:0]      n_line;
    logic                   w_hit;
    logic                   r_out_valid;
    logic [LINE_W-1:0]      r_out_line;

    assign w_entry = i_entry;

    // Take an entry when the output register is free or being drained
    assign o_pop = !i_empty && (!r_out_valid || o_match.ready);

    // Clear on a new text, count the newline, then step the match vector
    always_comb begin
        w_base_vec  = w_entry.fresh ? '0 : r_vec;
        w_base_line = w_entry.fresh ? '0 : r_line;
        if (w_entry.newline && (w_base_line != LINE_MAX_VALUE)) begin
            n_line = w_base_line + LINE_W'(1);
        end else begin
            n_line = w_base_line;
        end
        n_vec = ((w_base_vec << 1) | P_MAX_BYTES'(1)) & w_entry.mask;
        w_hit = |(n_vec & w_entry.last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec  <= '0;
            r_line <= '0;
        end else if (o_pop) begin
            r_vec  <= w_hit ? '0 : n_vec;
            r_line <= n_line;
        end
    end

    // Hold the match request until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && w_hit) begin
            r_out_valid <= 1'b1;
        end else if (o_match.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_hit) begin
            r_out_line <= n_line;
        end
    end

    assign o_match.valid      = r_out_valid;
    assign o_match.match_line = r_out_line;

endmodule

// ----- rtl/core/substring_match_line_reporter.sv -----
// Substring match line reporter: searches a byte stream for a configured
// pattern of up to 16 bytes and reports the zero-based line of each match.
// Depends on smlr_pkg, smlr_if, smlr_front, smlr_queue and smlr_back.
//
// Channels: i_text carries one text byte per request with a new-text flag,
// o_match carries one line number per completed occurrence, i_cfg writes
// the pattern low bytes (index 0), high bytes (index 1) and length (index 2).
// Configuration is always ready. The user must write it only while no text is
// in flight; the block does not enforce this. Throughput: one byte per cycle,
// set by the shift-and step in the back part, while the receiver keeps up.
// An accepted byte is written into the queue and a hit loads the output
// register. Occurrences never overlap: a match clears all partial progress.
// Reset clears the queue, the match vector, the line count and the output
// register, and loads an all-zero pattern of length one. When the receiver
// stalls, the output register holds its request, the four-entry queue fills
// and then i_text.ready drops until the receiver drains the output.
module substring_match_line_reporter #(
    parameter int P_MAX_BYTES = smlr_pkg::MAX_PATTERN_BYTES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    smlr_cfg_if.sink     i_cfg,
    smlr_text_if.sink    i_text,
    smlr_match_if.source o_match
);
    import smlr_pkg::*;

    localparam int ENTRY_W = 2 * P_MAX_BYTES + 2;

    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    logic [ENTRY_W-1:0] w_push_data;
    logic [ENTRY_W-1:0] w_pop_data;

    smlr_front #(.P_MAX_BYTES(P_MAX_BYTES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_text       (i_text),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_entry      (w_push_data)
    );

    smlr_queue #(.P_WIDTH(ENTRY_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_empty (w_empty)
    );

    smlr_back #(.P_MAX_BYTES(P_MAX_BYTES)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_entry (w_pop_data),
        .o_pop   (w_pop),
        .o_match (o_match)
    );

    // An accepted byte is queued on the next cycle
    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_text.valid && i_text.ready) |=> !w_empty)
        else $error("accepted byte missing from queue");

    // A new match request only follows a pop from the queue
    a_match_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_match.valid) |-> $past(w_pop))
        else $error("match request without queued byte");

    // Exactly one pattern position marks the end of the pattern
    a_last_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> $onehot(w_push_data[2*P_MAX_BYTES-1:P_MAX_BYTES]))
        else $error("pattern end position not one-hot");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for substring_match_line_reporter: directed, random and pressure phases.
// Depends on smlr_pkg and the channel interfaces in smlr_if; keeps its own shift-and predictor.
module testbench;
    import smlr_pkg::*;

    typedef enum logic {ROW_CFG, ROW_TEXT} t_row_kind;
    typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_LINE} t_line_check;

    typedef struct {
        t_row_kind              kind;
        t_cfg_reg               idx;
        logic [CFG_DATA_W-1:0]  value;
        logic                   fresh;
        t_line_check            check;
        logic [LINE_W-1:0]      line;
    } t_dir_row;

    localparam int N_DIR_ROWS = 27;

    logic i_clk;
    logic i_rst_n;

    smlr_cfg_if   cfg_bus ();
    smlr_text_if  text_bus ();
    smlr_match_if match_bus ();

    substring_match_line_reporter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_text  (text_bus),
        .o_match (match_bus)
    );

    // Predictor copy of the pattern registers and the matcher state
    logic [CFG_DATA_W-1:0] pat_low    = '0;
    logic [CFG_DATA_W-1:0] pat_high   = '0;
    logic [LEN_W-1:0]      pat_len    = 5'd1;
    logic [15:0]           prefix_vec = '0;
    logic [LINE_W-1:0]     line_no    = '0;

    // Line numbers still owed by the block, oldest first
    logic [LINE_W-1:0] pending_lines [$];

    int  mismatch_count = 0;
    bit  src_idle       = 1'b1;
    bit  snk_idle       = 1'b1;
    int  sink_gap       = 0;
    bit  hold_request   = 1'b0;
    bit  hold_off       = 1'b0;

    // Directed stimulus; typed lines only where they are obvious
    t_dir_row directed_rows [N_DIR_ROWS] = '{
        // after reset: pattern is one zero byte
        '{ROW_TEXT, CFG_PAT_LOW, 64'h00, 1'b1, CHK_LINE, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'hFF, 1'b0, CHK_NONE, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'h0A, 1'b0, CHK_NONE, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'h00, 1'b0, CHK_LINE, 32'd1},
        // "abc", overlapping prefix and a prefix broken by a newline
        '{ROW_CFG,  CFG_PAT_LOW, 64'hA5A5_A5A5_A563_6261, 1'b0, CHK_NONE, 32'd0},
        '{ROW_CFG,  CFG_PAT_LEN, 64'd3, 1'b0, CHK_NONE, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'h61, 1'b1, CHK_PREDICT, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'h61, 1'b0, CHK_PREDICT, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'h62, 1'b0, CHK_PREDICT, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'h63, 1'b0, CHK_PREDICT, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'h61, 1'b0, CHK_PREDICT, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'h62, 1'b0, CHK_PREDICT, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'h0A, 1'b0, CHK_PREDICT, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'h63, 1'b0, CHK_PREDICT, 32'd0},
        // "b\n": newline closing a match reports the following line
        '{ROW_CFG,  CFG_PAT_LOW, 64'h0A62, 1'b0, CHK_NONE, 32'd0},
        '{ROW_CFG,  CFG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFE2, 1'b0, CHK_NONE, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'h62, 1'b1, CHK_NONE, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'h0A, 1'b0, CHK_LINE, 32'd1},
        '{ROW_TEXT, CFG_PAT_LOW, 64'h0A, 1'b0, CHK_PREDICT, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'h62, 1'b0, CHK_PREDICT, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'h0A, 1'b0, CHK_PREDICT, 32'd0},
        // length zero acts as length one
        '{ROW_CFG,  CFG_PAT_LOW, 64'hFF, 1'b0, CHK_NONE, 32'd0},
        '{ROW_CFG,  CFG_PAT_LEN, 64'd0, 1'b0, CHK_NONE, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'hFF, 1'b1, CHK_LINE, 32'd0},
        '{ROW_TEXT, CFG_PAT_LOW, 64'hFF, 1'b0, CHK_LINE, 32'd0},
        // full high word, length above the maximum
        '{ROW_CFG,  CFG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, CHK_NONE, 32'd0},
        '{ROW_CFG,  CFG_PAT_LEN, 64'd17, 1'b0, CHK_NONE, 32'd0}
    };

    // Clock, 12 ns period
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Clamp a length code to the range in use
    function automatic int unsigned effective_len(input logic [LEN_W-1:0] code);
        if (code == 0) begin
            return 1;
        end
        if (code > MAX_PATTERN_BYTES) begin
            return MAX_PATTERN_BYTES;
        end
        return 32'(code);
    endfunction

    // Advance line count and shift-and vector by one byte; return 1 on a completed match
    function automatic logic advance_matcher(input logic [TEXT_W-1:0] b, input logic fresh,
                                             output logic [LINE_W-1:0] line);
        int unsigned n;
        logic [127:0] pat;
        logic [15:0]  hits;
        logic [15:0]  nxt;
        n    = effective_len(pat_len);
        pat  = {pat_high, pat_low};
        hits = '0;
        if (fresh) begin
            line_no    = '0;
            prefix_vec = '0;
        end
        if (b == NEWLINE_BYTE && line_no != LINE_MAX_VALUE) begin
            line_no = line_no + LINE_W'(1);
        end
        for (int i = 0; i < n; i++) begin
            if (pat[8*i +: 8] == b) begin
                hits[i] = 1'b1;
            end
        end
        nxt  = ((prefix_vec << 1) | 16'd1) & hits;
        line = line_no;
        if (nxt[n-1]) begin
            prefix_vec = '0;
            return 1'b1;
        end
        prefix_vec = nxt;
        return 1'b0;
    endfunction

    // Pick from a small alphabet so patterns overlap with themselves
    function automatic logic [TEXT_W-1:0] pick_symbol();
        case ($urandom_range(0, 2))
            0: begin
                return 8'h61;
            end
            1: begin
                return 8'h62;
            end
            default: begin
                return NEWLINE_BYTE;
            end
        endcase
    endfunction

    // Append one owed line number at the tail of the list
    task automatic owe_line(input logic [LINE_W-1:0] owed_line);
        pending_lines.insert(pending_lines.size(), owed_line);
    endtask

    // Offer one text request; enter and leave just after a rising edge
    task automatic push_text(input logic [TEXT_W-1:0] b, input logic fresh,
                             input t_line_check check, input logic [LINE_W-1:0] typed_line);
        int gap;
        logic hit;
        logic [LINE_W-1:0] line;
        gap = src_idle ? $urandom_range(0, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            text_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        text_bus.valid           = 1'b1;
        text_bus.text_byte       = b;
        text_bus.starts_new_text = fresh;
        @(posedge i_clk);
        while (!text_bus.ready) @(posedge i_clk);
        hit = advance_matcher(b, fresh, line);
        case (check)
            CHK_PREDICT: begin
                if (hit) begin
                    owe_line(line);
                end
            end
            CHK_LINE: begin
                owe_line(typed_line);
            end
            default: begin
            end
        endcase
    endtask

    // Drop text valid and wait until the block has drained
    task automatic settle_block();
        @(negedge i_clk);
        text_bus.valid = 1'b0;
        while (pending_lines.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write one configuration register and mirror it in the predictor
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        case (idx)
            CFG_PAT_LOW: begin
                pat_low = value;
            end
            CFG_PAT_HIGH: begin
                pat_high = value;
            end
            CFG_PAT_LEN: begin
                pat_len = value[LEN_W-1:0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
        @(posedge i_clk);
    endtask

    // One random phase: new pattern, then text built mostly from that pattern
    task automatic run_phase(input int unsigned count);
        logic [TEXT_W-1:0] pat [MAX_PATTERN_BYTES];
        logic [LEN_W-1:0]  code;
        logic [CFG_DATA_W-1:0] word;
        int unsigned n;
        int unsigned sent;
        int unsigned pick;
        int unsigned cut;
        int unsigned bad;
        bit alphabet;
        case ($urandom_range(0, 9))
            0: begin
                code = 5'd0;
            end
            1: begin
                code = 5'd16;
            end
            2: begin
                code = 5'($urandom_range(17, 31));
            end
            default: begin
                code = 5'($urandom_range(1, 6));
            end
        endcase
        n        = effective_len(code);
        alphabet = ($urandom_range(0, 1) != 0);
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            pat[i] = alphabet ? pick_symbol() : 8'($urandom_range(0, 255));
        end
        settle_block();
        write_reg(CFG_PAT_LOW, {pat[7], pat[6], pat[5], pat[4], pat[3], pat[2], pat[1], pat[0]});
        write_reg(CFG_PAT_HIGH, {pat[15], pat[14], pat[13], pat[12],
                                 pat[11], pat[10], pat[9], pat[8]});
        word       = {$urandom, $urandom};
        word[4:0]  = code;
        write_reg(CFG_PAT_LEN, word);
        src_idle = $urandom_range(0, 3) != 0;
        snk_idle = $urandom_range(0, 3) != 0;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                // whole occurrence, now and then with one byte spoiled
                bad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : n;
                for (int k = 0; k < n; k++) begin
                    push_text((k == bad) ? 8'($urandom_range(0, 255)) : pat[k],
                              $urandom_range(0, 39) == 0, CHK_PREDICT, '0);
                end
                sent += n;
            end else if (pick == 6) begin
                cut = $urandom_range(1, n);
                for (int k = 0; k < cut; k++) begin
                    push_text(pat[k], $urandom_range(0, 39) == 0, CHK_PREDICT, '0);
                end
                sent += cut;
            end else begin
                case (pick)
                    7: begin
                        push_text(NEWLINE_BYTE, $urandom_range(0, 39) == 0, CHK_PREDICT, '0);
                    end
                    8: begin
                        push_text(8'($urandom_range(0, 255)), $urandom_range(0, 39) == 0,
                                  CHK_PREDICT, '0);
                    end
                    default: begin
                        push_text(pick_symbol(), $urandom_range(0, 39) == 0, CHK_PREDICT, '0);
                    end
                endcase
                sent++;
            end
        end
    endtask

    // Compare each accepted match request with the oldest owed line
    always @(posedge i_clk) begin
        logic [LINE_W-1:0] owed;
        if (i_rst_n && match_bus.valid && match_bus.ready) begin
            if (pending_lines.size() == 0) begin
                $display("%0t: match_line expected none, got %0d", $time, match_bus.match_line);
                mismatch_count++;
            end else begin
                owed = pending_lines.pop_front();
                if (match_bus.match_line !== owed) begin
                    $display("%0t: match_line expected %0d, got %0d",
                             $time, owed, match_bus.match_line);
                    mismatch_count++;
                end
            end
            sink_gap = snk_idle ? $urandom_range(0, 3) : 0;
        end
    end

    // Drive the receiver's ready: long hold, per-request gap, else accept
    always @(negedge i_clk) begin
        if (hold_off) begin
            match_bus.ready = 1'b0;
        end else if (sink_gap > 0) begin
            match_bus.ready = 1'b0;
            sink_gap--;
        end else begin
            match_bus.ready = 1'b1;
        end
    end

    // Long receiver stall so the queue fills and text input backs up
    initial begin
        wait (hold_request);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (60) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #2_400_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Reset, directed table, random phases, pressure phase, drain
    initial begin
        i_rst_n                  = 1'b0;
        cfg_bus.valid            = 1'b0;
        cfg_bus.index            = CFG_PAT_LOW;
        cfg_bus.data             = '0;
        text_bus.valid           = 1'b0;
        text_bus.text_byte       = '0;
        text_bus.starts_new_text = 1'b0;
        match_bus.ready          = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR_ROWS; r++) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                settle_block();
                write_reg(directed_rows[r].idx, directed_rows[r].value);
            end else begin
                push_text(directed_rows[r].value[TEXT_W-1:0], directed_rows[r].fresh,
                          directed_rows[r].check, directed_rows[r].line);
            end
        end

        for (int p = 0; p < 10; p++) begin
            run_phase(65);
        end

        // Single-byte pattern hit by every byte while the receiver holds off
        settle_block();
        write_reg(CFG_PAT_LOW, {56'h5A5A_5A5A_5A5A_5A, 8'h61});
        write_reg(CFG_PAT_LEN, 64'd1);
        src_idle     = 1'b0;
        snk_idle     = 1'b1;
        hold_request = 1'b1;
        for (int k = 0; k < 40; k++) begin
            push_text(8'h61, 1'b0, CHK_PREDICT, '0);
        end

        settle_block();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/smlr_pkg.sv
rtl/core/smlr_if.sv
rtl/core/smlr_front.sv
rtl/core/smlr_queue.sv
rtl/core/smlr_back.sv
rtl/core/substring_match_line_reporter.sv
verif/testbench.sv
